// File: design/acldac_pkg.sv
// ----------------------------------------------------------------------------
// acldac_pkg
// Shared types and constants of the averaged, clamped linear DAC channel.
// ----------------------------------------------------------------------------
package acldac_pkg;

  localparam int CODE_W  = 16;
  localparam int CNT_W   = 16;
  localparam int MUL_W   = 16;
  localparam int DEN_W   = 16;
  localparam int CFG_A_W = 3;

  typedef struct packed {
    logic              op;
    logic signed [15:0] sample_value;
    logic        [1:0] mode;
    logic              bus_busy;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] dac_code;
    logic        [1:0] code_source;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL,
    ST_SCALE,
    ST_PUT
  } state_t;

  // Input operation and mode codes
  localparam logic       OP_SAMPLE    = 1'b0;
  localparam logic       OP_TICK      = 1'b1;
  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_SAMPLE  = 2'd1;
  localparam logic [1:0] MODE_WARMUP  = 2'd2;
  localparam logic [1:0] MODE_ERROR   = 2'd3;

  // Result source codes
  localparam logic [1:0] SRC_SCALED = 2'd0;
  localparam logic [1:0] SRC_WARMUP = 2'd1;
  localparam logic [1:0] SRC_ERROR  = 2'd2;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_INPUT_LOW     = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_INPUT_HIGH    = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_OUTPUT_LOW    = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_OUTPUT_HIGH   = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_UPDATE_PERIOD = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_WARMUP_CODE   = 3'd5;
  localparam logic [CFG_A_W-1:0] REG_ERROR_CODE    = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_INPUT_LOW     = 16'd500;
  localparam logic [15:0] RST_INPUT_HIGH    = 16'd1523;
  localparam logic [15:0] RST_OUTPUT_LOW    = 16'd0;
  localparam logic [15:0] RST_OUTPUT_HIGH   = 16'd4095;
  localparam logic [15:0] RST_UPDATE_PERIOD = 16'd1;
  localparam logic [15:0] RST_WARMUP_CODE   = 16'd0;
  localparam logic [15:0] RST_ERROR_CODE    = 16'd0;

  localparam logic [15:0] SCALE_MASK = 16'h0FFF;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [15:0] AVG_MAX    = 16'h7FFF;
  localparam logic [15:0] AVG_MIN    = 16'h8000;

endpackage

// File: design/acldac_div.sv
// ----------------------------------------------------------------------------
// acldac_div
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module acldac_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   den_ext;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Bring the next numerator bit into the partial remainder
  assign trial   = {rem, quo[NUM_W-1]};
  assign den_ext = {1'b0, den_r};
  assign ge      = (trial >= den_ext);
  assign diff    = trial - den_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

// File: design/acldac_mul.sv
// ----------------------------------------------------------------------------
// acldac_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module acldac_mul #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     a_r;
  logic [W-1:0]     hi;
  logic [W-1:0]     lo;
  logic [W:0]       psum;

  // Add the multiplicand when the current multiplier bit is set
  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= psum[W:1];
      lo <= {psum[0], lo[W-1:1]};
    end
  end

endmodule

// File: design/averaged_clamped_linear_dac_channel.sv
// ----------------------------------------------------------------------------
// averaged_clamped_linear_dac_channel
// One analog output channel: sample averaging, two-point scaling with clamp.
// ----------------------------------------------------------------------------
// Takes one item at a time. Timer ticks and samples that do not trigger an
// update leave the channel idle; warm-up and error requests load their code
// straight into the result. A sample that triggers an update runs the
// average through a bit-serial divider of N = max(SUM_WIDTH, 32) bits; a
// clamped result then goes to the output. An interpolated one also needs
// the 16-bit serial multiplier and a second pass through the same divider.
// A result waits in the output register until taken; the next item is not
// taken while a result is still being formed.
module averaged_clamped_linear_dac_channel #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  acldac_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output acldac_pkg::out_item_t             out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [acldac_pkg::CFG_A_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);

  import acldac_pkg::*;

  localparam int SW    = SUM_WIDTH;
  localparam int NUM_W = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  // Configuration
  logic signed [15:0] input_low;
  logic signed [15:0] input_high;
  logic signed [15:0] output_low;
  logic signed [15:0] output_high;
  logic        [15:0] update_period;
  logic signed [15:0] warmup_code;
  logic signed [15:0] error_code;

  // Accumulation state
  logic signed [SW-1:0] sample_sum;
  logic [CNT_W-1:0]     sample_count;
  logic [15:0]          period_timer;

  state_t    state;
  state_t    state_next;
  out_item_t res;
  out_item_t res_next;
  logic      res_load;
  logic      out_load;
  logic      avg_neg;
  logic      prod_neg;

  logic               in_acc;
  logic               sample_op;
  logic               fire;
  logic [15:0]        timer_eff;
  logic signed [SW:0] sum_wide;
  logic signed [SW-1:0] sum_sat;
  logic [SW-1:0]      sum_mag;
  logic [CNT_W-1:0]   count_inc;

  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic               mul_start;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic               mul_done;
  logic [2*MUL_W-1:0] mul_prod;

  logic signed [15:0] avg_v;
  logic               lo_hit;
  logic               hi_hit;
  logic signed [16:0] span_in;
  logic signed [16:0] span_out;
  logic        [16:0] span_out_mag;
  logic signed [16:0] offset;
  logic [11:0]        q_low;
  logic [11:0]        q_signed;
  logic [11:0]        code12;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign sample_op = (in_data.op == OP_SAMPLE) &&
                     ((in_data.mode == MODE_RESTART) || (in_data.mode == MODE_SAMPLE));
  assign timer_eff = (in_data.mode == MODE_RESTART) ? 16'd0 : period_timer;
  assign fire      = sample_op && !in_data.bus_busy && (timer_eff == 16'd0);

  // Saturating accumulate
  assign sum_wide = {sample_sum[SW-1], sample_sum} +
                    (SW+1)'({{(SW-15){in_data.sample_value[15]}}, in_data.sample_value});
  always_comb begin
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
  end
  assign sum_mag   = sum_sat[SW-1] ? (~sum_sat + 1'b1) : sum_sat;
  assign count_inc = (sample_count == COUNT_MAX) ? COUNT_MAX : sample_count + 1'b1;

  // Truncated average, saturated to 16 bits
  always_comb begin
    if (avg_neg) begin
      if (div_quo > NUM_W'(32768)) begin
        avg_v = AVG_MIN;
      end else begin
        avg_v = ~div_quo[15:0] + 1'b1;
      end
    end else begin
      if (div_quo > NUM_W'(32767)) begin
        avg_v = AVG_MAX;
      end else begin
        avg_v = div_quo[15:0];
      end
    end
  end

  assign lo_hit       = (avg_v <= input_low);
  assign hi_hit       = (avg_v >= input_high);
  assign offset       = {avg_v[15], avg_v} - {input_low[15], input_low};
  assign span_in      = {input_high[15], input_high} - {input_low[15], input_low};
  assign span_out     = {output_high[15], output_high} - {output_low[15], output_low};
  assign span_out_mag = span_out[16] ? (~span_out + 1'b1) : span_out;

  // Only the low twelve bits survive the mask
  assign q_low    = div_quo[11:0];
  assign q_signed = prod_neg ? (~q_low + 1'b1) : q_low;
  assign code12   = output_low[11:0] + q_signed;

  assign out_load = (state == ST_PUT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    res_load   = 1'b0;
    res_next   = res;
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.op == OP_SAMPLE)) begin
          if (in_data.mode == MODE_WARMUP) begin
            res_next.dac_code    = warmup_code;
            res_next.code_source = SRC_WARMUP;
            res_load             = 1'b1;
            state_next           = ST_PUT;
          end else if (in_data.mode == MODE_ERROR) begin
            res_next.dac_code    = error_code;
            res_next.code_source = SRC_ERROR;
            res_load             = 1'b1;
            state_next           = ST_PUT;
          end else if (fire) begin
            div_start  = 1'b1;
            div_num    = NUM_W'(sum_mag);
            div_den    = count_inc;
            state_next = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        if (div_done) begin
          if (lo_hit) begin
            res_next.dac_code    = output_low;
            res_next.code_source = SRC_SCALED;
            res_load             = 1'b1;
            state_next           = ST_PUT;
          end else if (hi_hit) begin
            res_next.dac_code    = output_high;
            res_next.code_source = SRC_SCALED;
            res_load             = 1'b1;
            state_next           = ST_PUT;
          end else begin
            mul_start  = 1'b1;
            mul_a      = offset[15:0];
            mul_b      = span_out_mag[15:0];
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_num    = NUM_W'(mul_prod);
          div_den    = span_in[15:0];
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          res_next.dac_code    = {4'b0000, code12};
          res_next.code_source = SRC_SCALED;
          res_load             = 1'b1;
          state_next           = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      input_low     <= RST_INPUT_LOW;
      input_high    <= RST_INPUT_HIGH;
      output_low    <= RST_OUTPUT_LOW;
      output_high   <= RST_OUTPUT_HIGH;
      update_period <= RST_UPDATE_PERIOD;
      warmup_code   <= RST_WARMUP_CODE;
      error_code    <= RST_ERROR_CODE;
      sample_sum    <= '0;
      sample_count  <= '0;
      period_timer  <= '0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_INPUT_LOW:     input_low     <= cfg_data;
          REG_INPUT_HIGH:    input_high    <= cfg_data;
          REG_OUTPUT_LOW:    output_low    <= cfg_data;
          REG_OUTPUT_HIGH:   output_high   <= cfg_data;
          REG_UPDATE_PERIOD: update_period <= cfg_data;
          REG_WARMUP_CODE:   warmup_code   <= cfg_data;
          REG_ERROR_CODE:    error_code    <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc) begin
        if (in_data.op == OP_TICK) begin
          if (period_timer != 16'd0) begin
            period_timer <= period_timer - 1'b1;
          end
        end else if (fire) begin
          // Update taken: reload the timer and start a fresh average
          period_timer <= update_period;
          sample_sum   <= '0;
          sample_count <= '0;
        end else if (sample_op) begin
          sample_sum   <= sum_sat;
          sample_count <= count_inc;
          if (in_data.mode == MODE_RESTART) begin
            period_timer <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
    if (out_load) begin
      out_data <= res;
    end
    if (div_start && (state == ST_IDLE)) begin
      avg_neg <= sum_sat[SW-1];
    end
    if (mul_start) begin
      prod_neg <= span_out[16];
    end
  end

  acldac_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  acldac_mul #(
    .W (MUL_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

endmodule

// File: design/acldac_checker.sv
// ----------------------------------------------------------------------------
// acldac_checker
// Port-level checks of the averaged, clamped linear DAC channel.
// ----------------------------------------------------------------------------
module acldac_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input acldac_pkg::in_item_t           in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input acldac_pkg::out_item_t          out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [acldac_pkg::CFG_A_W-1:0] cfg_index,
  input logic [15:0]                    cfg_data
);

  import acldac_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid && !in_stall;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_source_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.code_source == SRC_SCALED) ||
                  (out_data.code_source == SRC_WARMUP) ||
                  (out_data.code_source == SRC_ERROR))
    else $error("result carries an unused source code");

  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_data.op == OP_TICK) && !out_valid |=> !out_valid)
    else $error("timer tick produced a result");

  a_warmup_fast: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_data.op == OP_SAMPLE) && (in_data.mode == MODE_WARMUP) && !out_valid
    |-> ##2 out_valid && (out_data.code_source == SRC_WARMUP))
    else $error("warm-up request not answered in two cycles");

endmodule

bind averaged_clamped_linear_dac_channel acldac_checker u_acldac_checker (.*);

// File: test/dac_channel_check.sv
// ----------------------------------------------------------------------------
// dac_channel_check
// Watches the sample, result and register channels of the DAC channel, keeps
// its own copy of the channel state, and compares every result it sees.
// ----------------------------------------------------------------------------
module dac_channel_check #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  acldac_pkg::in_item_t             in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  acldac_pkg::out_item_t            out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [acldac_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data,
  output int                               pending,
  output int                               mismatches,
  output int                               compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import acldac_pkg::*;

  localparam longint SUM_TOP    = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_BOTTOM = -SUM_TOP - 1;
  localparam longint AVG_TOP    = 32767;
  localparam longint AVG_BOTTOM = -32768;

  logic signed [15:0] in_lo, in_hi, out_lo, out_hi, warm_code, err_code;
  logic        [15:0] period;
  longint             acc_sum;
  int                 acc_count;
  int                 timer;
  out_item_t          code_queue[$];

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic load_register(input logic [CFG_A_W-1:0] idx, input logic [15:0] value);
    case (idx)
      REG_INPUT_LOW:     in_lo = value;
      REG_INPUT_HIGH:    in_hi = value;
      REG_OUTPUT_LOW:    out_lo = value;
      REG_OUTPUT_HIGH:   out_hi = value;
      REG_UPDATE_PERIOD: period = value;
      REG_WARMUP_CODE:   warm_code = value;
      REG_ERROR_CODE:    err_code = value;
      default: ;
    endcase
  endtask

  // Truncated average, clamped at both ends, interpolated and masked between.
  function automatic logic [15:0] scaled_code();
    longint avg;
    longint q;
    avg = (acc_count != 0) ? acc_sum / longint'(acc_count) : 0;
    if (avg > AVG_TOP) avg = AVG_TOP;
    if (avg < AVG_BOTTOM) avg = AVG_BOTTOM;
    if (avg <= longint'(in_lo)) return out_lo;
    if (avg >= longint'(in_hi)) return out_hi;
    q = ((avg - longint'(in_lo)) * (longint'(out_hi) - longint'(out_lo)))
        / (longint'(in_hi) - longint'(in_lo));
    return 16'(longint'(out_lo) + q) & SCALE_MASK;
  endfunction

  function automatic bit advance_channel(input in_item_t it, output out_item_t res);
    longint s;
    res = '0;
    if (it.op == OP_TICK) begin
      if (timer != 0) timer--;
      return 1'b0;
    end
    if (it.mode == MODE_WARMUP) begin
      res.dac_code    = warm_code;
      res.code_source = SRC_WARMUP;
      return 1'b1;
    end
    if (it.mode == MODE_ERROR) begin
      res.dac_code    = err_code;
      res.code_source = SRC_ERROR;
      return 1'b1;
    end
    if (it.mode == MODE_RESTART) timer = 0;
    s = acc_sum + longint'($signed(it.sample_value));
    if (s > SUM_TOP) s = SUM_TOP;
    if (s < SUM_BOTTOM) s = SUM_BOTTOM;
    acc_sum = s;
    if (acc_count < int'(COUNT_MAX)) acc_count++;
    if (it.bus_busy || timer != 0) return 1'b0;
    timer = int'(period);
    res.dac_code    = scaled_code();
    res.code_source = SRC_SCALED;
    acc_sum   = 0;
    acc_count = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (rst) begin
      in_lo      = RST_INPUT_LOW;
      in_hi      = RST_INPUT_HIGH;
      out_lo     = RST_OUTPUT_LOW;
      out_hi     = RST_OUTPUT_HIGH;
      period     = RST_UPDATE_PERIOD;
      warm_code  = RST_WARMUP_CODE;
      err_code   = RST_ERROR_CODE;
      acc_sum    = 0;
      acc_count  = 0;
      timer      = 0;
      mismatches = 0;
      compared   = 0;
      code_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        if (advance_channel(in_data, fresh)) code_queue.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        if (code_queue.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, dac_code %0d source %0d",
                                    $signed(out_data.dac_code), out_data.code_source));
        end else begin
          want = code_queue.pop_front();
          compared++;
          if (out_data.dac_code !== want.dac_code) begin
            report_mismatch($sformatf("dac_code %0d, expected %0d",
                                      $signed(out_data.dac_code), $signed(want.dac_code)));
          end
          if (out_data.code_source !== want.code_source) begin
            report_mismatch($sformatf("code_source %0d, expected %0d",
                                      out_data.code_source, want.code_source));
          end
        end
      end
    end
    pending <= code_queue.size();
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the DAC channel with directed and random sample, tick, warm-up and
// error transfers under several register settings, with random sender gaps
// and receiver stalls; the checker beside the block predicts every code.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acldac_pkg::*;

  localparam int SUM_W       = 32;
  localparam int PHASES      = 7;
  localparam int PER_PHASE   = 120;
  localparam int SAT_RUN     = 8;
  localparam int DRAIN       = 120;
  localparam int CYCLE_LIMIT = 1200000;

  localparam logic [CFG_A_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_A_W-1:0]   cfg_index;
  logic [15:0]          cfg_data;

  int pending;
  int mismatches;
  int compared;
  int items_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int cur_lo;
  int cur_hi;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  averaged_clamped_linear_dac_channel #(.SUM_WIDTH(SUM_W)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dac_channel_check #(.SUM_WIDTH(SUM_W)) chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches), .compared(compared)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("averaged_clamped_linear_dac_channel test failed");
      $finish;
    end
  end

  // Receiver: stretches of no stall, light stall, heavy stall and long runs.
  initial begin
    int hold;
    int style;
    hold  = 0;
    style = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        hold  = $urandom_range(32, 256);
        style = $urandom_range(0, 3);
      end
      hold--;
      case (style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
      endcase
    end
  end

  function automatic in_item_t mk(input logic op, input int value, input logic [1:0] mode,
                                  input logic busy);
    in_item_t it;
    it.op           = op;
    it.sample_value = 16'(value);
    it.mode         = mode;
    it.bus_busy     = busy;
    return it;
  endfunction

  // Hold the payload until the transfer; valid stays up for the caller.
  task automatic send_item(input in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int value);
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input int p);
    int lo, hi, olo, ohi, per, wc, ec;
    case (p)
      1: begin
        lo = -32768; hi = 32767; olo = -32768; ohi = 32767; per = 0;
        wc = 32767; ec = -32768;
      end
      2: begin
        lo = 32767; hi = -32768; olo = 32767; ohi = -32768; per = 65535;
        wc = -32768; ec = 32767;
      end
      3: begin
        lo = 0; hi = 0; olo = -1; ohi = 1; per = 2; wc = -1; ec = 16'h5A5A;
      end
      4: begin
        lo = -100; hi = 100; olo = 4095; ohi = -4096; per = 3; wc = 16'h1234; ec = -2;
      end
      default: begin
        lo  = int'($urandom_range(0, 65535)) - 32768;
        hi  = lo + int'($urandom_range(1, 3000));
        if (hi > 32767) hi = 32767;
        olo = int'($urandom_range(0, 65535)) - 32768;
        ohi = int'($urandom_range(0, 65535)) - 32768;
        per = $urandom_range(0, 4);
        wc  = $urandom_range(0, 65535);
        ec  = $urandom_range(0, 65535);
      end
    endcase
    write_reg(REG_INPUT_LOW, lo);
    write_reg(REG_INPUT_HIGH, hi);
    write_reg(REG_OUTPUT_LOW, olo);
    write_reg(REG_OUTPUT_HIGH, ohi);
    write_reg(REG_UPDATE_PERIOD, per);
    write_reg(REG_WARMUP_CODE, wc);
    write_reg(REG_ERROR_CODE, ec);
    // an index past the last register must change nothing
    if (p == 2) write_reg(REG_UNUSED, $urandom_range(0, 65535));
    cfg_valid <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Mostly short coherent runs of samples and ticks; some pure noise.
  task automatic run_random(input int count);
    int done, seq_len, kind, lo_v, hi_v, r, v;
    bit noisy;
    in_item_t it;
    done = 0;
    while (done < count) begin
      seq_len = $urandom_range(1, 8);
      noisy   = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 2);
      lo_v = ((cur_lo < cur_hi) ? cur_lo : cur_hi) - 64;
      hi_v = ((cur_lo < cur_hi) ? cur_hi : cur_lo) + 64;
      if (lo_v < -32768) lo_v = -32768;
      if (hi_v > 32767) hi_v = 32767;
      repeat (seq_len) begin
        if (noisy) begin
          it = in_item_t'($urandom);
        end else begin
          case (kind)
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = lo_v + int'($urandom_range(0, hi_v - lo_v));
            default: begin
              case ($urandom_range(0, 3))
                0: v = 32767;
                1: v = -32768;
                2: v = -1;
                default: v = 0;
              endcase
            end
          endcase
          r  = $urandom_range(0, 99);
          it = mk(OP_SAMPLE, v, MODE_SAMPLE, $urandom_range(0, 3) == 0);
          if (r < 25) it.op = OP_TICK;
          else if (r < 37) it.mode = MODE_RESTART;
          else if (r >= 94) it.mode = MODE_ERROR;
          else if (r >= 88) it.mode = MODE_WARMUP;
        end
        send_item(it);
        pace();
        done++;
      end
    end
  endtask

  initial begin
    in_item_t plan[$];
    int p;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    cur_lo = 500;
    cur_hi = 1523;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan = '{
      mk(OP_TICK,   0,      MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 1000,   MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 32767,  MODE_SAMPLE,  1'b0),
      mk(OP_TICK,   -1,     MODE_ERROR,   1'b1),
      mk(OP_SAMPLE, -32768, MODE_SAMPLE,  1'b1),
      mk(OP_SAMPLE, 0,      MODE_SAMPLE,  1'b0),
      mk(OP_SAMPLE, -1,     MODE_WARMUP,  1'b1),
      mk(OP_SAMPLE, 0,      MODE_ERROR,   1'b0),
      mk(OP_SAMPLE, 500,    MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 1523,   MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 501,    MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 1522,   MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 1011,   MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 32767,  MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, -32768, MODE_RESTART, 1'b0),
      mk(OP_SAMPLE, 100,    MODE_RESTART, 1'b1),
      mk(OP_SAMPLE, 2000,   MODE_SAMPLE,  1'b0),
      mk(OP_TICK,   0,      MODE_SAMPLE,  1'b0)
    };
    foreach (plan[i]) begin
      send_item(plan[i]);
      pace();
    end

    // Short busy runs of full-scale samples, each closed by an update of
    // their average.
    repeat (SAT_RUN) send_item(mk(OP_SAMPLE, 32767, 2'($urandom_range(0, 1)), 1'b1));
    send_item(mk(OP_SAMPLE, 32767, MODE_RESTART, 1'b0));
    repeat (SAT_RUN) send_item(mk(OP_SAMPLE, -32768, 2'($urandom_range(0, 1)), 1'b1));
    send_item(mk(OP_SAMPLE, -32768, MODE_RESTART, 1'b0));
    pace();

    run_random(PER_PHASE);
    for (p = 1; p < PHASES; p++) begin
      settle();
      configure(p);
      run_random(PER_PHASE);
    end
    settle();

    $display("%0d transfers sent over %0d register settings, full-scale busy runs included",
             items_sent, PHASES);
    $display("%0d codes compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("averaged_clamped_linear_dac_channel test passed");
    end else begin
      $display("averaged_clamped_linear_dac_channel test failed");
    end
    $finish;
  end

endmodule
